FILE: sv/bffa_pkg.sv
`default_nettype none

package bffa_pkg;

  // field widths fixed by the item format
  localparam int INDEX_W     = 10;
  localparam int COUNT_W     = 11;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  // bitmap organisation: 32 usage bits per memory word
  localparam int WORD_W     = 32;
  localparam int WORD_SHIFT = 5;
  localparam int INDEX_SPAN = 1 << INDEX_W;
  localparam int POOL_SIZE_DEF = 1024;
  localparam int MAX_WORDS  = INDEX_SPAN / WORD_W;

  // reset values
  localparam logic [COUNT_W-1:0] COUNT_RESET  = COUNT_W'(1014);
  localparam logic [INDEX_W-1:0] LOWEST_RESET = INDEX_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LOWEST_INDEX = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_FREE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_ALLOC = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE
  } state_t;

  // control from the sequencer to the bitmap store
  typedef struct packed {
    logic we;
    logic clear;
  } mem_ctl_t;

endpackage

`default_nettype wire

FILE: sv/bffa_if.sv
`default_nettype none

interface bffa_in_if import bffa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output mode, output index, input ready);
  modport sink   (input valid, input mode, input index, output ready);
endinterface

interface bffa_out_if import bffa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  granted_index;
  logic [COUNT_W-1:0]  free_count;

  modport source (output valid, output status, output granted_index, output free_count,
                  input ready);
  modport sink   (input valid, input status, input granted_index, input free_count,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/bffa_bitmap_store.sv
`default_nettype none

module bffa_bitmap_store import bffa_pkg::*; #(
  parameter int DEPTH = MAX_WORDS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire mem_ctl_t                               ctl,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WORD_W-1:0]                      wr_data,
  output logic      [WORD_W-1:0]                      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] raw_r;
  logic [DEPTH-1:0]  valid_r, valid_nxt;
  logic              rd_valid_r;
  logic              rd_zero_r;

  // word storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[wr_addr] <= wr_data;
    end
    raw_r      <= mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
    rd_zero_r  <= (rd_addr == AW'(0));
  end

  // per-word written flags, cleared all at once by initialise
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = '0;
    end else if (ctl.we) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // unwritten words read as the pool's initial image: entry zero used
  assign rd_data = rd_valid_r ? raw_r : (rd_zero_r ? WORD_W'(1) : '0);

endmodule

`default_nettype wire

FILE: sv/bitmap_first_fit_allocator.sv
`default_nettype none
// channel   dir  beat contents
// in_ch     in   mode, index
// out_ch    out  status, granted_index, free_count
// cfg_*     in   cfg_we, cfg_index, cfg_wdata (no read-back)
//
// Allocate walks the bitmap memory one 32-bit word per cycle from the word holding
// lowest_index until a free entry is found or the last word of the pool is read; with
// lowest_index past the pool it answers full without scanning. Free reads the word,
// then writes it back; initialise and other modes answer directly. One request is in
// flight at a time and a result waiting on out_ch holds off the next request. Synchronous
// reset restores the initial pool at once through per-word flags, so there is no clearing pass.

module bitmap_first_fit_allocator import bffa_pkg::*; #(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  bffa_in_if.sink                     in_ch,
  bffa_out_if.source                  out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int ACTIVE = (POOL_SIZE < INDEX_SPAN) ? POOL_SIZE : INDEX_SPAN;
  localparam int WORDS  = (ACTIVE + WORD_W - 1) / WORD_W;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0]      LAST_WORD = AW'(WORDS - 1);
  localparam logic [COUNT_W-1:0] ACTIVE_C  = COUNT_W'(ACTIVE);

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            word_r;
  logic [WORD_SHIFT-1:0]    bit_r;
  logic [COUNT_W-1:0]       count_r, count_nxt;
  logic [INDEX_W-1:0]       lowest_r;
  logic [COUNT_W-1:0]       init_free_r;
  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic [INDEX_W-1:0]       out_grant_r;
  logic [COUNT_W-1:0]       out_count_r;

  logic                     in_ready;
  logic                     accept;
  logic                     low_in_range;
  logic                     idx_in_range;
  logic [AW-1:0]            rd_addr;
  logic [WORD_W-1:0]        rd_data;
  logic [WORD_W-1:0]        wr_data;
  mem_ctl_t                 mem_ctl;
  logic [WORD_W-1:0]        avail;
  logic [WORD_SHIFT-1:0]    pick;
  logic                     hit;
  logic [COUNT_W-1:0]       pick_g;
  logic                     res_load;
  status_t                  res_status;
  logic [INDEX_W-1:0]       res_grant;

  // bitmap memory
  bffa_bitmap_store #(
    .DEPTH (WORDS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (word_r),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // input handshake
  assign in_ready     = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = in_ready;
  assign accept       = in_ch.valid && in_ready;
  assign low_in_range = ({1'b0, lowest_r} < ACTIVE_C);
  assign idx_in_range = ({1'b0, in_ch.index} < ACTIVE_C);

  // free entries in the word under scan, within the allowed range
  always_comb begin
    logic [COUNT_W-1:0] g;
    for (int b = 0; b < WORD_W; b++) begin
      g = (COUNT_W'(word_r) << WORD_SHIFT) | COUNT_W'(b);
      avail[b] = !rd_data[b] && (g >= {1'b0, lowest_r}) && (g < ACTIVE_C);
    end
  end

  // lowest free bit
  always_comb begin
    pick = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        pick = WORD_SHIFT'(b);
      end
    end
  end

  assign hit    = |avail;
  assign pick_g = (COUNT_W'(word_r) << WORD_SHIFT) | COUNT_W'(pick);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_ch.mode == MODE_ALLOC) && low_in_range) begin
            state_nxt = ST_SCAN;
          end else if ((in_ch.mode == MODE_FREE) && idx_in_range) begin
            state_nxt = ST_FREE;
          end
        end
      end
      ST_SCAN: begin
        if (hit || (word_r == LAST_WORD)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FREE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    rd_addr    = word_r;
    wr_data    = rd_data;
    mem_ctl    = '0;
    count_nxt  = count_r;
    res_load   = 1'b0;
    res_status = STATUS_OK;
    res_grant  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.mode)
            MODE_ALLOC: begin
              rd_addr = AW'(lowest_r >> WORD_SHIFT);
              if (!low_in_range) begin
                res_load   = 1'b1;
                res_status = STATUS_FULL;
              end
            end
            MODE_FREE: begin
              rd_addr = AW'(in_ch.index >> WORD_SHIFT);
              if (!idx_in_range) begin
                res_load   = 1'b1;
                res_status = STATUS_NOT_ALLOC;
              end
            end
            MODE_INIT: begin
              mem_ctl.clear = 1'b1;
              count_nxt     = init_free_r;
              res_load      = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        rd_addr = (word_r == LAST_WORD) ? word_r : word_r + AW'(1);
        wr_data = rd_data | (WORD_W'(1) << pick);
        if (hit) begin
          mem_ctl.we = 1'b1;
          count_nxt  = (count_r != '0) ? count_r - COUNT_W'(1) : count_r;
          res_load   = 1'b1;
          res_grant  = pick_g[INDEX_W-1:0];
        end else if (word_r == LAST_WORD) begin
          res_load   = 1'b1;
          res_status = STATUS_FULL;
        end
      end
      ST_FREE: begin
        wr_data  = rd_data & ~(WORD_W'(1) << bit_r);
        res_load = 1'b1;
        if (rd_data[bit_r]) begin
          mem_ctl.we = 1'b1;
          count_nxt  = (count_r != COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;
        end else begin
          res_status = STATUS_NOT_ALLOC;
        end
      end
      default: begin
        rd_addr = word_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= COUNT_RESET;
      lowest_r    <= LOWEST_RESET;
      init_free_r <= COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOWEST_INDEX: lowest_r    <= cfg_wdata[INDEX_W-1:0];
          CFG_INITIAL_FREE: init_free_r <= cfg_wdata[COUNT_W-1:0];
          default:          lowest_r    <= lowest_r;
        endcase
      end
    end
  end

  // scan pointer, bit select and result beat
  always_ff @(posedge clk) begin
    word_r <= rd_addr;
    if (accept) begin
      bit_r <= in_ch.index[WORD_SHIFT-1:0];
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_grant_r  <= res_grant;
      out_count_r  <= count_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.granted_index = out_grant_r;
  assign out_ch.free_count    = out_count_r;

endmodule

`default_nettype wire

FILE: verif/bitmap_first_fit_allocator_test.sv
`timescale 1ns / 100ps

module bitmap_first_fit_allocator_test import bffa_pkg::*;;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int DIRECTED_ROWS   = 20;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 54;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  granted_index;
    logic [COUNT_W-1:0]  free_count;
  } pool_reply_t;

  // typed flag set: reply below is the expected beat, else the predictor decides
  typedef struct packed {
    bit          typed;
    pool_reply_t reply;
  } reply_note_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] index;
    reply_note_t        note;
  } request_row_t;

  logic clk;
  logic rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  bffa_in_if  alloc_req ();
  bffa_out_if alloc_rsp ();

  bitmap_first_fit_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (alloc_req),
    .out_ch    (alloc_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow pool state
  bit [INDEX_SPAN-1:0] usage_map;
  logic [COUNT_W-1:0]  free_cnt;
  logic [INDEX_W-1:0]  lowest_reg;
  logic [COUNT_W-1:0]  seed_reg;

  pool_reply_t pool_replies_q[$];
  reply_note_t typed_q[$];

  bit calm;
  int error_count;
  int cycle_count;
  int request_total;
  int grant_total;
  int full_total;
  int reject_total;
  int phase_total;

  // directed rows from the reset state: lowest index 1, counter 1014, entry 0 used
  request_row_t directed_rows [DIRECTED_ROWS] = '{
    '{MODE_ALLOC, 10'h000, '{1'b1, '{STATUS_OK,        10'd1, 11'd1013}}},
    '{MODE_ALLOC, 10'h000, '{1'b1, '{STATUS_OK,        10'd2, 11'd1012}}},
    '{MODE_ALLOC, 10'h3FF, '{1'b1, '{STATUS_OK,        10'd3, 11'd1011}}},
    '{MODE_FREE,  10'h002, '{1'b1, '{STATUS_OK,        10'd0, 11'd1012}}},
    '{MODE_FREE,  10'h002, '{1'b1, '{STATUS_NOT_ALLOC, 10'd0, 11'd1012}}},
    '{MODE_FREE,  10'h000, '{1'b1, '{STATUS_OK,        10'd0, 11'd1013}}},
    '{MODE_FREE,  10'h000, '{1'b1, '{STATUS_NOT_ALLOC, 10'd0, 11'd1013}}},
    '{MODE_FREE,  10'h3FF, '{1'b1, '{STATUS_NOT_ALLOC, 10'd0, 11'd1013}}},
    '{MODE_NONE,  10'h3FF, '{1'b1, '{STATUS_OK,        10'd0, 11'd1013}}},
    '{MODE_ALLOC, 10'h000, '{1'b1, '{STATUS_OK,        10'd2, 11'd1012}}},
    '{MODE_FREE,  10'h001, '{1'b1, '{STATUS_OK,        10'd0, 11'd1013}}},
    '{MODE_ALLOC, 10'h155, '{1'b1, '{STATUS_OK,        10'd1, 11'd1012}}},
    '{MODE_ALLOC, 10'h2AA, '{1'b1, '{STATUS_OK,        10'd4, 11'd1011}}},
    '{MODE_FREE,  10'h155, '{1'b1, '{STATUS_NOT_ALLOC, 10'd0, 11'd1011}}},
    '{MODE_FREE,  10'h2AA, '{1'b1, '{STATUS_NOT_ALLOC, 10'd0, 11'd1011}}},
    '{MODE_INIT,  10'h3FF, '{1'b1, '{STATUS_OK,        10'd0, 11'd1014}}},
    '{MODE_ALLOC, 10'h000, '{1'b1, '{STATUS_OK,        10'd1, 11'd1013}}},
    '{MODE_FREE,  10'h200, '{1'b1, '{STATUS_NOT_ALLOC, 10'd0, 11'd1013}}},
    '{MODE_ALLOC, 10'h1C3, '{1'b0, '0}},
    '{MODE_FREE,  10'h001, '{1'b0, '0}}
  };

  // clock and watchdog
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d replies outstanding", $time, cycle_count,
               pool_replies_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void clear_usage_map();
    usage_map    = '0;
    usage_map[0] = 1'b1;
  endfunction

  // first-fit pool behaviour for one request
  function automatic pool_reply_t predict_request(logic [MODE_W-1:0] m,
                                                  logic [INDEX_W-1:0] idx);
    pool_reply_t r;
    bit hit;
    r.status        = STATUS_OK;
    r.granted_index = '0;
    hit             = 1'b0;
    case (m)
      MODE_ALLOC: begin
        for (int e = int'(lowest_reg); e < INDEX_SPAN && !hit; e++) begin
          if (!usage_map[e]) begin
            usage_map[e] = 1'b1;
            if (free_cnt != '0) free_cnt = free_cnt - 1'b1;
            r.granted_index = INDEX_W'(e);
            hit = 1'b1;
          end
        end
        if (hit) grant_total++;
        else begin
          r.status = STATUS_FULL;
          full_total++;
        end
      end
      MODE_FREE: begin
        if (usage_map[idx]) begin
          usage_map[idx] = 1'b0;
          if (free_cnt != COUNT_MAX) free_cnt = free_cnt + 1'b1;
        end else begin
          r.status = STATUS_NOT_ALLOC;
          reject_total++;
        end
      end
      MODE_INIT: begin
        clear_usage_map();
        free_cnt = seed_reg;
      end
      default: ;
    endcase
    r.free_count = free_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [COUNT_W-1:0] want_v,
                                      logic [COUNT_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      error_count++;
    end
  endfunction

  // predictor update and reply checking
  always @(posedge clk) begin
    pool_reply_t want;
    pool_reply_t guess;
    reply_note_t note;
    if (!rst_n) begin
      clear_usage_map();
      free_cnt   = COUNT_RESET;
      lowest_reg = LOWEST_RESET;
      seed_reg   = COUNT_RESET;
    end else begin
      if (alloc_rsp.valid && alloc_rsp.ready) begin
        if (pool_replies_q.size() == 0) begin
          $display("%0t: unexpected reply beat, status %0d granted %0d count %0d", $time,
                   alloc_rsp.status, alloc_rsp.granted_index, alloc_rsp.free_count);
          error_count++;
        end else begin
          want = pool_replies_q.pop_front();
          check_field("status", COUNT_W'(want.status), COUNT_W'(alloc_rsp.status));
          check_field("granted_index", COUNT_W'(want.granted_index),
                      COUNT_W'(alloc_rsp.granted_index));
          check_field("free_count", want.free_count, alloc_rsp.free_count);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOWEST_INDEX: lowest_reg = cfg_wdata[INDEX_W-1:0];
          CFG_INITIAL_FREE: seed_reg   = cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (alloc_req.valid && alloc_req.ready) begin
        guess = predict_request(alloc_req.mode, alloc_req.index);
        note  = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
        pool_replies_q.push_back(note.typed ? note.reply : guess);
        request_total++;
      end
    end
  end

  // reply side back-pressure in bursts
  initial begin
    int stall;
    stall = 0;
    alloc_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && stall > 0) begin
        alloc_rsp.ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        alloc_rsp.ready <= 1'b0;
        stall = $urandom_range(0, 12);
      end else begin
        alloc_rsp.ready <= 1'b1;
      end
    end
  end

  // one request beat, with an optional idle burst ahead of it
  task automatic send_request(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] idx,
                              input reply_note_t note);
    if (!calm && $urandom_range(0, 3) == 0) begin
      alloc_req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    typed_q.push_back(note);
    alloc_req.valid <= 1'b1;
    alloc_req.mode  <= m;
    alloc_req.index <= idx;
    do @(posedge clk); while (!alloc_req.ready);
  endtask

  // stop sending and wait for every outstanding reply
  task automatic drain_replies();
    alloc_req.valid <= 1'b0;
    do @(posedge clk); while (pool_replies_q.size() != 0);
  endtask

  task automatic configure_pool(input logic [INDEX_W-1:0] lowest,
                                input logic [COUNT_W-1:0] seed);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOWEST_INDEX;
    cfg_wdata <= CFG_DATA_W'(lowest);
    @(posedge clk);
    cfg_index <= CFG_INITIAL_FREE;
    cfg_wdata <= CFG_DATA_W'(seed);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stimulus
  initial begin
    int phase_lowest;
    int phase_seed;
    int alloc_pct;
    int pick;
    int pos;
    logic [MODE_W-1:0]  m;
    logic [INDEX_W-1:0] idx;
    calm          = 1'b0;
    error_count   = 0;
    request_total = 0;
    grant_total   = 0;
    full_total    = 0;
    reject_total  = 0;
    phase_total   = 0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_LOWEST_INDEX;
    cfg_wdata       <= '0;
    alloc_req.valid <= 1'b0;
    alloc_req.mode  <= MODE_ALLOC;
    alloc_req.index <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows at reset settings
    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_request(directed_rows[r].mode, directed_rows[r].index, directed_rows[r].note);

    // random phases, each under its own register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          phase_lowest = INDEX_SPAN - 1;
          phase_seed   = 0;
        end
        1: begin
          phase_lowest = 0;
          phase_seed   = int'(COUNT_MAX);
        end
        2: begin
          phase_lowest = 1008;
          phase_seed   = INDEX_SPAN;
        end
        3: begin
          phase_lowest = 1;
          phase_seed   = 1014;
        end
        default: begin
          phase_lowest = $urandom_range(0, 1) ? $urandom_range(1000, INDEX_SPAN - 1)
                                              : $urandom_range(0, INDEX_SPAN - 1);
          phase_seed   = $urandom_range(0, int'(COUNT_MAX));
        end
      endcase
      alloc_pct = (phase_lowest >= 960) ? 75 : 50;

      drain_replies();
      calm = (phase == PHASES - 1);
      configure_pool(INDEX_W'(phase_lowest), COUNT_W'(phase_seed));
      phase_total++;
      if (phase < 4 || $urandom_range(0, 3) != 0)
        send_request(MODE_INIT, INDEX_W'($urandom), '0);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        idx  = INDEX_W'($urandom);
        if (pick < alloc_pct) begin
          m = MODE_ALLOC;
        end else if (pick < 90) begin
          // frees mostly land near the allocation window
          m = MODE_FREE;
          if ($urandom_range(0, 3) != 0) begin
            pos = phase_lowest + $urandom_range(0, 40);
            if (pos > INDEX_SPAN - 1) pos = INDEX_SPAN - 1 - $urandom_range(0, 15);
            idx = INDEX_W'(pos);
          end
        end else if (pick < 96) begin
          m = MODE_INIT;
        end else begin
          m = MODE_NONE;
        end
        send_request(m, idx, '0);
      end
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests over %0d register settings plus reset defaults",
             request_total, phase_total);
    $display("grants %0d, pool full %0d, rejected frees %0d, mismatches %0d",
             grant_total, full_total, reject_total, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/bffa_pkg.sv
sv/bffa_if.sv
sv/bffa_bitmap_store.sv
sv/bitmap_first_fit_allocator.sv
verif/bitmap_first_fit_allocator_test.sv
